// ----- rtl/core/mce_pkg.sv -----
// Package: payload types, register indexes and fixed widths of the modexp cipher unit.
`timescale 1ns / 1ps
`default_nettype none
package mce_pkg;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CNT_BITS = $clog2(VALUE_BITS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_PUB_EXP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIV_EXP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 2'd2;

  localparam logic [VALUE_BITS-1:0] PUB_EXP_RESET  = 16'd6239;
  localparam logic [VALUE_BITS-1:0] PRIV_EXP_RESET = 16'd3119;
  localparam logic [VALUE_BITS-1:0] MODULUS_RESET  = 16'd34393;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [VALUE_BITS-1:0] value;
    logic                  final_item;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] result;
    logic                  final_result;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] x;
    logic [VALUE_BITS-1:0] y;
    logic [VALUE_BITS-1:0] m;
  } mul_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/mce_mulmod.sv -----
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module mce_mulmod
  import mce_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire mul_req_t              req,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      prod
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] x_r, x_nxt;
  logic [VALUE_BITS-1:0] y_r, y_nxt;
  logic [VALUE_BITS-1:0] m_r, m_nxt;
  logic [VALUE_BITS:0]   dbl;
  logic [VALUE_BITS:0]   dbl_red;
  logic [VALUE_BITS:0]   sum;
  logic [VALUE_BITS:0]   sum_red;

  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = dbl_red + {1'b0, x_r};
    if (!y_r[VALUE_BITS-1]) begin
      sum_red = dbl_red;
    end else if (sum >= {1'b0, m_r}) begin
      sum_red = sum - {1'b0, m_r};
    end else begin
      sum_red = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
      m_nxt    = req.m;
    end else if (busy_r) begin
      acc_nxt = sum_red[VALUE_BITS-1:0];
      y_nxt   = {y_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_BITS'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ----- rtl/core/modexp_cipher_unit_core.sv -----
// Top level: modular exponentiation cipher unit with square-and-multiply sequencer.
//
// Input channel in_valid/in_ready carries an item: opcode, value, final_item.
// Opcode encrypt raises the low byte of value to the public exponent modulo
// the modulus; decrypt raises the whole word to the private exponent and keeps
// the low byte. Each item gives one result item on out_valid/out_ready.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it. One item at a time:
// the base is first reduced, then each exponent bit above bit 0 costs a
// squaring plus a multiply when the bit is set, stopping after the highest
// set bit; the first multiply of each item is a multiply by one. A modulus
// below two gives result zero with no multiply; a base that reduces to zero
// gives zero and a zero exponent gives one, both right after the reduction.
// Each product takes 16 multiplier bits, one bit per cycle; the start to the
// multiplier and its done are both registered.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and the block holds its own result until the output is free.
// Synchronous reset restores the register defaults and empties the block.
`timescale 1ns / 1ps
`default_nettype none
module modexp_cipher_unit_core
  import mce_pkg::*;
#(
  parameter int unsigned WORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_item_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_item_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [VALUE_BITS-1:0]   cfg_wdata
);

  localparam logic [VALUE_BITS-1:0] WordMask = (WORD_BITS >= VALUE_BITS) ?
      {VALUE_BITS{1'b1}} : VALUE_BITS'((64'd1 << WORD_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_MUL,
    S_SQR,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] pub_exp_r, pub_exp_nxt;
  logic [VALUE_BITS-1:0] priv_exp_r, priv_exp_nxt;
  logic [VALUE_BITS-1:0] modulus_r, modulus_nxt;
  logic                  op_r, op_nxt;
  logic                  fin_r, fin_nxt;
  logic [VALUE_BITS-1:0] base_r, base_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] expo_r, expo_nxt;
  logic                  start_r, start_nxt;
  mul_req_t              req_r, req_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic                  mul_done;
  logic [VALUE_BITS-1:0] mul_prod;
  logic                  in_acc;
  logic                  out_free;
  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] res_fmt;

  mce_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .req   (req_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_val   = in_data.value & WordMask;
  assign res_fmt  = ((op_r == OP_DECRYPT) ? {8'd0, acc_r[7:0]} : acc_r) & WordMask;

  always_comb begin
    state_nxt     = state_r;
    pub_exp_nxt   = pub_exp_r;
    priv_exp_nxt  = priv_exp_r;
    modulus_nxt   = modulus_r;
    op_nxt        = op_r;
    fin_nxt       = fin_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    expo_nxt      = expo_r;
    start_nxt     = 1'b0;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PUB_EXP:  pub_exp_nxt  = cfg_wdata;
        CFG_PRIV_EXP: priv_exp_nxt = cfg_wdata;
        CFG_MODULUS:  modulus_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_data.opcode;
          fin_nxt  = in_data.final_item;
          expo_nxt = (in_data.opcode == OP_DECRYPT) ? priv_exp_r : pub_exp_r;
          base_nxt = (in_data.opcode == OP_DECRYPT) ? in_val : {8'd0, in_val[7:0]};
          if (modulus_r < VALUE_BITS'(2)) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            req_nxt   = '{x: VALUE_BITS'(1), y: base_nxt, m: modulus_r};
            start_nxt = 1'b1;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (mul_done) begin
          base_nxt = mul_prod;
          if (mul_prod == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else if (expo_r == '0) begin
            acc_nxt   = VALUE_BITS'(1);
            state_nxt = S_DONE;
          end else if (expo_r[0]) begin
            acc_nxt   = VALUE_BITS'(1);
            req_nxt   = '{x: VALUE_BITS'(1), y: mul_prod, m: req_r.m};
            start_nxt = 1'b1;
            state_nxt = S_MUL;
          end else begin
            acc_nxt   = VALUE_BITS'(1);
            req_nxt   = '{x: mul_prod, y: mul_prod, m: req_r.m};
            start_nxt = 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          acc_nxt = mul_prod;
          if (expo_r[VALUE_BITS-1:1] == '0) begin
            state_nxt = S_DONE;
          end else begin
            req_nxt   = '{x: base_r, y: base_r, m: req_r.m};
            start_nxt = 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mul_done) begin
          base_nxt = mul_prod;
          expo_nxt = {1'b0, expo_r[VALUE_BITS-1:1]};
          if (expo_nxt[0]) begin
            req_nxt   = '{x: acc_r, y: mul_prod, m: req_r.m};
            start_nxt = 1'b1;
            state_nxt = S_MUL;
          end else begin
            req_nxt   = '{x: mul_prod, y: mul_prod, m: req_r.m};
            start_nxt = 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result: res_fmt, final_result: fin_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pub_exp_r   <= PUB_EXP_RESET;
      priv_exp_r  <= PRIV_EXP_RESET;
      modulus_r   <= MODULUS_RESET;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pub_exp_r   <= pub_exp_nxt;
      priv_exp_r  <= priv_exp_nxt;
      modulus_r   <= modulus_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    fin_r      <= fin_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    expo_r     <= expo_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
